/* rtl/string_escape_decoder_top_assert.svh */
// Assertion macros used by the string escape decoder top level.
`ifndef STRING_ESCAPE_DECODER_TOP_ASSERT_SVH
`define STRING_ESCAPE_DECODER_TOP_ASSERT_SVH

// Condition must never hold while out of reset.
`define SED_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define SED_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/sed_pkg.sv */
// Shared types and constants of the string escape decoder.
package sed_pkg;

  // Result kinds.
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_CLOSE    = 2'd1;
  localparam logic [1:0] KIND_UNCLOSED = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ILLEGAL  = 2'd1;
  localparam logic [1:0] ERR_NEWLINE  = 2'd2;
  localparam logic [1:0] ERR_END      = 2'd3;

  // Configuration register indexes.
  localparam int          CFG_IDX_W       = 1;
  localparam logic [0:0]  CFG_QUOTE_BYTE  = 1'd0;
  localparam logic [0:0]  CFG_CLOSE_REQ   = 1'd1;

  // Configuration reset values.
  localparam logic [7:0]  QUOTE_RESET     = 8'h22;
  localparam logic        CLOSE_REQ_RESET = 1'b1;

  // Characters.
  localparam logic [7:0] CH_N          = 8'h6E;
  localparam logic [7:0] CH_R          = 8'h72;
  localparam logic [7:0] CH_B          = 8'h62;
  localparam logic [7:0] CH_T          = 8'h74;
  localparam logic [7:0] CH_F          = 8'h66;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;
  localparam logic [7:0] CH_APOS       = 8'h27;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_BS         = 8'h08;
  localparam logic [7:0] CH_HT         = 8'h09;
  localparam logic [7:0] CH_FF         = 8'h0C;
  localparam logic [7:0] CH_0          = 8'h30;
  localparam logic [7:0] CH_7          = 8'h37;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  // Result queue depth; one input item produces at most two results.
  localparam int RQ_DEPTH   = 4;
  localparam int RQ_PTR_W   = 2;
  localparam int RQ_LEVEL_W = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  // Results produced by the decoder for one input item.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } dec_out_t;

  // Result queue status seen by the top level.
  typedef struct packed {
    logic [RQ_LEVEL_W-1:0] level;
    logic                  room_for_two;
  } rq_status_t;

endpackage

/* rtl/sed_decode.sv */
// Escape decoding logic and decode state of the string escape decoder.
module sed_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        in_byte,
  input  logic              at_end,
  input  logic [7:0]        quote_byte,
  input  logic              close_required,
  output sed_pkg::dec_out_t dec_out
);
  import sed_pkg::*;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESCAPE,
    MODE_OCTAL
  } mode_t;

  mode_t      mode, mode_next;
  logic [7:0] octal_value, octal_value_next;

  // Normal text handling of the current byte.
  logic  t_has;
  res_t  t_res;
  mode_t t_mode;
  logic  is_octal_digit;

  assign is_octal_digit = (in_byte >= CH_0) && (in_byte <= CH_7);

  always_comb begin
    t_has  = 1'b0;
    t_mode = MODE_TEXT;
    t_res  = '{kind: KIND_BYTE, value: in_byte, error_code: ERR_NONE, last: 1'b1};
    if (at_end) begin
      t_has       = 1'b1;
      t_res.value = 8'd0;
      if (close_required) begin
        t_res.kind       = KIND_ERROR;
        t_res.error_code = ERR_END;
      end else begin
        t_res.kind = KIND_UNCLOSED;
      end
    end else if (in_byte == quote_byte) begin
      t_has       = 1'b1;
      t_res.kind  = KIND_CLOSE;
      t_res.value = 8'd0;
    end else if (in_byte == CH_BACKSLASH) begin
      t_mode = MODE_ESCAPE;
    end else if ((in_byte == CH_LF) && close_required) begin
      t_has            = 1'b1;
      t_res.kind       = KIND_ERROR;
      t_res.value      = 8'd0;
      t_res.error_code = ERR_NEWLINE;
    end else begin
      t_has = 1'b1;
    end
  end

  always_comb begin
    mode_next        = mode;
    octal_value_next = octal_value;
    dec_out.count    = 2'd0;
    dec_out.res0     = t_res;
    dec_out.res1     = t_res;
    unique case (mode)
      MODE_ESCAPE: begin
        mode_next        = MODE_TEXT;
        octal_value_next = 8'd0;
        dec_out.res0     = '{kind: KIND_BYTE, value: 8'd0, error_code: ERR_NONE, last: 1'b1};
        if (at_end) begin
          dec_out.count           = 2'd1;
          dec_out.res0.kind       = KIND_ERROR;
          dec_out.res0.error_code = ERR_END;
        end else if (is_octal_digit) begin
          mode_next        = MODE_OCTAL;
          octal_value_next = {5'd0, in_byte[2:0]};
        end else begin
          dec_out.count = 2'd1;
          unique case (in_byte)
            CH_N:         dec_out.res0.value = CH_LF;
            CH_R:         dec_out.res0.value = CH_CR;
            CH_B:         dec_out.res0.value = CH_BS;
            CH_T:         dec_out.res0.value = CH_HT;
            CH_F:         dec_out.res0.value = CH_FF;
            CH_BACKSLASH: dec_out.res0.value = CH_BACKSLASH;
            CH_SLASH:     dec_out.res0.value = CH_SLASH;
            CH_DQUOTE:    dec_out.res0.value = CH_DQUOTE;
            CH_APOS:      dec_out.res0.value = CH_APOS;
            CH_LF:        dec_out.count      = 2'd0;
            default: begin
              dec_out.res0.kind       = KIND_ERROR;
              dec_out.res0.error_code = ERR_ILLEGAL;
            end
          endcase
        end
      end
      MODE_OCTAL: begin
        if (!at_end && (in_byte == CH_UNDERSCORE)) begin
          mode_next = MODE_OCTAL;
        end else if (!at_end && is_octal_digit) begin
          octal_value_next = {octal_value[4:0], in_byte[2:0]};
        end else begin
          // The run ends: emit its value, then treat this byte as plain text.
          dec_out.res0     = '{kind: KIND_BYTE, value: octal_value,
                               error_code: ERR_NONE, last: !t_has};
          dec_out.res1     = t_res;
          dec_out.count    = t_has ? 2'd2 : 2'd1;
          mode_next        = t_mode;
          octal_value_next = 8'd0;
        end
      end
      default: begin
        dec_out.count    = {1'b0, t_has};
        mode_next        = t_mode;
        octal_value_next = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_TEXT;
      octal_value <= 8'd0;
    end else if (fire) begin
      mode        <= mode_next;
      octal_value <= octal_value_next;
    end
  end

endmodule

/* rtl/sed_result_queue.sv */
// Result queue that takes up to two results a cycle and delivers one.
module sed_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  sed_pkg::res_t       push_res0,
  input  sed_pkg::res_t       push_res1,
  input  logic                pop,
  output logic                head_valid,
  output sed_pkg::res_t       head,
  output sed_pkg::rq_status_t status
);
  import sed_pkg::*;

  res_t                  entries [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [RQ_LEVEL_W-1:0] level;
  logic [RQ_PTR_W-1:0]   wr_ptr_plus1;

  assign wr_ptr_plus1        = wr_ptr + RQ_PTR_W'(1);
  assign head_valid          = (level != '0);
  assign head                = entries[rd_ptr];
  assign status.level        = level;
  assign status.room_for_two = (level <= RQ_LEVEL_W'(RQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push_res0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_plus1] <= push_res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PTR_W'(push_count);
      rd_ptr <= rd_ptr + RQ_PTR_W'(pop);
      level  <= level + RQ_LEVEL_W'(push_count) - RQ_LEVEL_W'(pop);
    end
  end

endmodule

/* rtl/string_escape_decoder_top.sv */
// Top level of the string escape decoder.
//
// The block decodes the body of a quoted string, one source byte per input
// transfer (in_byte, at_end on in_valid/in_ready), and sends decoded bytes and
// end-of-string events as result transfers (kind, value, error_code, last on
// out_valid/out_ready). One input byte gives zero, one or two results; last
// marks the final result caused by that byte.
// Configuration is written on cfg_valid/cfg_ready with cfg_index selecting
// the quote byte (index 0) or the close-required flag (index 1). The port is
// always ready and should only be written while the block is idle.
// With the queue empty, a result is offered once its input byte has passed the
// input register and been written into the result queue. Throughput: one input
// byte per cycle while each byte gives at most one result and the receiver keeps
// up; a byte that gives two results sends them one after the other on the
// single-result output port.
// A four-entry result queue parts the two sides, so input keeps flowing while
// the receiver stalls until the queue cannot take two more results.
// Synchronous reset returns the decoder to plain text mode, empties the queue
// and restores the quote byte to double quote with closing required.
module string_escape_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte,
  input  logic                              at_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        kind,
  output logic [7:0]                        value,
  output logic [1:0]                        error_code,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sed_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                        cfg_data
);
  import sed_pkg::*;

  // Configuration registers.
  logic [7:0] quote_byte;
  logic       close_required;

  // Input register.
  logic       inq_valid;
  logic [7:0] inq_byte;
  logic       inq_end;

  logic       dec_fire;
  dec_out_t   dec_out;
  rq_status_t rq_status;
  res_t       head;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_byte     <= QUOTE_RESET;
      close_required <= CLOSE_REQ_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_QUOTE_BYTE: quote_byte     <= cfg_data;
        CFG_CLOSE_REQ:  close_required <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The registered byte is decoded once the queue can hold both results it
  // may give; the input register refills in the same cycle.
  assign dec_fire = inq_valid && rq_status.room_for_two;
  assign in_ready = !inq_valid || dec_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte <= in_byte;
      inq_end  <= at_end;
    end
  end

  sed_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .fire           (dec_fire),
    .in_byte        (inq_byte),
    .at_end         (inq_end),
    .quote_byte     (quote_byte),
    .close_required (close_required),
    .dec_out        (dec_out)
  );

  assign pop = out_valid && out_ready;

  sed_result_queue u_result_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (dec_fire ? dec_out.count : 2'd0),
    .push_res0  (dec_out.res0),
    .push_res1  (dec_out.res1),
    .pop        (pop),
    .head_valid (out_valid),
    .head       (head),
    .status     (rq_status)
  );

  assign kind       = head.kind;
  assign value      = head.value;
  assign error_code = head.error_code;
  assign last       = head.last;

  `include "string_escape_decoder_top_assert.svh"

  `SED_ASSERT_NEVER(a_queue_level, clk, rst, rq_status.level > RQ_LEVEL_W'(RQ_DEPTH), "result queue overflow")
  `SED_ASSERT_IMPLY(a_event_value, clk, rst, out_valid && (kind != KIND_BYTE), (value == 8'd0) && last, "end-of-string result must carry zero value and last")
  `SED_ASSERT_IMPLY(a_error_code, clk, rst, out_valid, (kind == KIND_ERROR) == (error_code != ERR_NONE), "error code disagrees with result kind")
  `SED_ASSERT_IMPLY(a_pair_order, clk, rst, dec_fire && (dec_out.count == 2'd2), !dec_out.res0.last && dec_out.res1.last, "two-result item must mark only its second result last")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the string escape decoder against a cycle-free predictor.
module testbench;
  import sed_pkg::*;

  // Length of the random part, spread evenly over the configuration phases.
  localparam int RAND_ITEMS = 1650;
  localparam int N_PHASES = 6;
  // The top level passes a byte through its input register and result queue; this leaves margin.
  localparam int SETTLE_CYCLES = 6;
  // Far above the slowest legal run: every byte giving two results, each result
  // held back by the longest receiver stall, and each byte behind the longest source gap.
  localparam int CYCLE_LIMIT = 400000;

  // Decoder modes of the predictor.
  typedef enum logic [1:0] {
    DEC_TEXT   = 2'd0,
    DEC_ESCAPE = 2'd1,
    DEC_OCTAL  = 2'd2
  } dec_mode_t;

  // One source byte to send. When typed is set, the result written in the row
  // is what the block must return (zero or one result); otherwise the
  // predictor decides.
  typedef struct {
    logic [7:0] in_byte;
    logic       at_end;
    bit         typed;
    int         n_res;
    res_t       res;
  } src_row_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_byte    = 8'h00;
  logic                 at_end     = 1'b0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic [1:0]           kind;
  logic [7:0]           value;
  logic [1:0]           error_code;
  logic                 last;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_QUOTE_BYTE;
  logic [7:0]           cfg_data   = 8'h00;

  string_escape_decoder_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .at_end     (at_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .value      (value),
    .error_code (error_code),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state, a copy of the configuration registers, and the results
  // still owed by the block in the order it must deliver them.
  dec_mode_t  dec_mode  = DEC_TEXT;
  logic [7:0] octal_acc = 8'h00;
  logic [7:0] quote_sel = QUOTE_RESET;
  logic       close_req = CLOSE_REQ_RESET;
  res_t       step_res[$];
  res_t       pending_res[$];

  // Once set, neither side inserts idle cycles any more.
  bit calm = 1'b0;

  int fails = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int kind_seen[4] = '{0, 0, 0, 0};
  int cycles = 0;

  logic [7:0] escape_chars[9] = '{CH_N, CH_R, CH_B, CH_T, CH_F, CH_BACKSLASH, CH_SLASH,
                                  CH_DQUOTE, CH_APOS};
  // Settings of the random phases; the extremes of the quote byte, backslash as
  // the quote, and both values of the close-required flag. The last phase goes
  // back to the reset settings and runs without idling.
  logic [7:0] phase_quote[N_PHASES] = '{8'h22, 8'h00, 8'hFF, CH_BACKSLASH, CH_APOS, QUOTE_RESET};
  logic       phase_close[N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, CLOSE_REQ_RESET};

  function automatic res_t make_res(logic [1:0] k, logic [7:0] v, logic [1:0] ec, logic l);
    res_t r;
    r.kind       = k;
    r.value      = v;
    r.error_code = ec;
    r.last       = l;
    return r;
  endfunction

  function automatic src_row_t typed_row(logic [7:0] b, logic e, int n, res_t r);
    src_row_t row;
    row.in_byte = b;
    row.at_end  = e;
    row.typed   = 1'b1;
    row.n_res   = n;
    row.res     = r;
    return row;
  endfunction

  function automatic src_row_t free_row(logic [7:0] b, logic e);
    src_row_t row;
    row.in_byte = b;
    row.at_end  = e;
    row.typed   = 1'b0;
    row.n_res   = 0;
    row.res     = make_res(KIND_BYTE, 8'h00, ERR_NONE, 1'b0);
    return row;
  endfunction

  function automatic bit is_octal(logic [7:0] b);
    return b >= CH_0 && b <= CH_7;
  endfunction

  function automatic bit is_escape(logic [7:0] b);
    foreach (escape_chars[i]) begin
      if (b == escape_chars[i]) return 1'b1;
    end
    return b == CH_LF;
  endfunction

  function automatic void decoded(logic [7:0] v);
    step_res.push_back(make_res(KIND_BYTE, v, ERR_NONE, 1'b0));
  endfunction

  // A close, an unclosed end or an error ends the string and returns to text mode.
  function automatic void end_string(logic [1:0] k, logic [1:0] ec);
    dec_mode  = DEC_TEXT;
    octal_acc = 8'h00;
    step_res.push_back(make_res(k, 8'h00, ec, 1'b0));
  endfunction

  // Plain text handling; also applied to the byte that ends an octal run.
  // The quote test comes before the backslash test, so a backslash quote closes.
  function automatic void text_char(logic [7:0] b, logic e);
    if (e) begin
      if (close_req) end_string(KIND_ERROR, ERR_END);
      else end_string(KIND_UNCLOSED, ERR_NONE);
    end else if (b == quote_sel) begin
      end_string(KIND_CLOSE, ERR_NONE);
    end else if (b == CH_BACKSLASH) begin
      dec_mode = DEC_ESCAPE;
    end else if (b == CH_LF && close_req) begin
      end_string(KIND_ERROR, ERR_NEWLINE);
    end else begin
      decoded(b);
    end
  endfunction

  // Works out the results of one source byte into step_res and marks the final one.
  function automatic void predict_byte(logic [7:0] b, logic e);
    res_t r;
    step_res.delete();
    case (dec_mode)
      DEC_ESCAPE: begin
        if (e) begin
          end_string(KIND_ERROR, ERR_END);
        end else if (is_octal(b)) begin
          dec_mode  = DEC_OCTAL;
          octal_acc = b - CH_0;
        end else begin
          dec_mode = DEC_TEXT;
          case (b)
            CH_N: decoded(CH_LF);
            CH_R: decoded(CH_CR);
            CH_B: decoded(CH_BS);
            CH_T: decoded(CH_HT);
            CH_F: decoded(CH_FF);
            CH_BACKSLASH, CH_SLASH, CH_DQUOTE, CH_APOS: decoded(b);
            CH_LF: ;  // Line continuation gives nothing.
            default: end_string(KIND_ERROR, ERR_ILLEGAL);
          endcase
        end
      end
      DEC_OCTAL: begin
        if (!e && b == CH_UNDERSCORE) begin
          // Underscores inside a run are skipped.
        end else if (!e && is_octal(b)) begin
          octal_acc = octal_acc * 8'd8 + (b - CH_0);  // Only the low 8 bits are kept.
        end else begin
          decoded(octal_acc);
          dec_mode  = DEC_TEXT;
          octal_acc = 8'h00;
          text_char(b, e);
        end
      end
      default: text_char(b, e);
    endcase
    if (step_res.size() > 0) begin
      r      = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
  endfunction

  // Sends one byte, possibly after a burst of idle cycles. Valid is left high
  // after the transfer so that back-to-back bytes never toggle it.
  task automatic send_byte(input src_row_t row);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= row.in_byte;
    at_end   <= row.at_end;
    do @(posedge clk); while (!in_ready);
    predict_byte(row.in_byte, row.at_end);
    if (row.typed) begin
      if (row.n_res > 0) pending_res.push_back(row.res);
    end else begin
      foreach (step_res[i]) pending_res.push_back(step_res[i]);
    end
    bytes_sent++;
  endtask

  // Holds the source back until every owed result has come out and the block
  // has had time to settle.
  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers in two back-to-back transfers.
  task automatic set_config(logic [7:0] q, logic c);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_QUOTE_BYTE;
    cfg_data  <= q;
    do @(posedge clk); while (!cfg_ready);
    quote_sel = q;
    cfg_index <= CFG_CLOSE_REQ;
    cfg_data  <= {7'b0, c};
    do @(posedge clk); while (!cfg_ready);
    close_req = c;
    cfg_valid <= 1'b0;
  endtask

  // Sends one random string. Most are well formed (plain bytes, escapes,
  // octal runs, line continuations, then a closing quote); the rest end in an
  // error or an end marker, or are unstructured noise.
  task automatic send_random_string;
    int         roll;
    int         digits;
    logic [7:0] b;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 8)) begin
        send_byte(free_row(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0));
      end
      return;
    end
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          do b = 8'($urandom_range(0, 255));
          while (b == quote_sel || b == CH_BACKSLASH || (b == CH_LF && close_req));
          send_byte(free_row(b, 1'b0));
        end
        4, 5: begin
          send_byte(free_row(CH_BACKSLASH, 1'b0));
          send_byte(free_row(escape_chars[$urandom_range(0, 8)], 1'b0));
        end
        6, 7, 8: begin
          // Octal run; whatever follows ends it, at times a decimal 8 or 9.
          send_byte(free_row(CH_BACKSLASH, 1'b0));
          digits = $urandom_range(1, 5);
          repeat (digits) begin
            if ($urandom_range(0, 4) == 0) send_byte(free_row(CH_UNDERSCORE, 1'b0));
            send_byte(free_row(8'(CH_0 + $urandom_range(0, 7)), 1'b0));
          end
          if ($urandom_range(0, 3) == 0) begin
            send_byte(free_row(8'("8" + $urandom_range(0, 1)), 1'b0));
          end
        end
        default: begin
          send_byte(free_row(CH_BACKSLASH, 1'b0));
          send_byte(free_row(CH_LF, 1'b0));
        end
      endcase
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      send_byte(free_row(quote_sel, 1'b0));
    end else if (roll < 80) begin
      send_byte(free_row(8'($urandom_range(0, 255)), 1'b1));
    end else if (roll < 88) begin
      do b = 8'($urandom_range(0, 255));
      while (is_escape(b) || is_octal(b));
      send_byte(free_row(CH_BACKSLASH, 1'b0));
      send_byte(free_row(b, 1'b0));
    end else if (roll < 94) begin
      send_byte(free_row(CH_LF, 1'b0));
    end else begin
      send_byte(free_row(CH_BACKSLASH, 1'b0));
      send_byte(free_row(8'($urandom_range(0, 255)), 1'b1));
    end
  endtask

  // Receiver: ready drops in random bursts between stretches of varying length,
  // and stays high once the run turns calm.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  // Every result transfer is compared field by field with the oldest owed result.
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && out_valid && out_ready) begin
      got = make_res(kind, value, error_code, last);
      if (pending_res.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%02h error_code %0d last %0d",
               kind, value, error_code, last);
        fails++;
      end else begin
        want = pending_res.pop_front();
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind);
          fails++;
        end
        if (got.value !== want.value) begin
          $error("value: expected 0x%02h, got 0x%02h", want.value, got.value);
          fails++;
        end
        if (got.error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
          fails++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last);
          fails++;
        end
      end
      results_seen++;
      if (!$isunknown(kind)) kind_seen[kind]++;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles with %0d results still owed", cycles, pending_res.size());
      $display("status: fail");
      $finish;
    end
  end

  // Main sequence: reset, the directed table at the reset settings, then one
  // random phase per setting, with the source drained before each register write.
  initial begin
    src_row_t directed[$];
    int       phase_end;

    directed = '{
      // Extremes of the byte range pass straight through.
      typed_row(8'h00, 1'b0, 1, make_res(KIND_BYTE, 8'h00, ERR_NONE, 1'b1)),
      typed_row(8'hFF, 1'b0, 1, make_res(KIND_BYTE, 8'hFF, ERR_NONE, 1'b1)),
      typed_row(CH_BACKSLASH, 1'b0, 0, make_res(KIND_BYTE, 8'h00, ERR_NONE, 1'b0)),
      typed_row(CH_N, 1'b0, 1, make_res(KIND_BYTE, CH_LF, ERR_NONE, 1'b1)),
      // The apostrophe escape gives an apostrophe, not a backslash.
      typed_row(CH_BACKSLASH, 1'b0, 0, make_res(KIND_BYTE, 8'h00, ERR_NONE, 1'b0)),
      typed_row(CH_APOS, 1'b0, 1, make_res(KIND_BYTE, CH_APOS, ERR_NONE, 1'b1)),
      // Line continuation gives nothing and must not swallow the next byte.
      typed_row(CH_BACKSLASH, 1'b0, 0, make_res(KIND_BYTE, 8'h00, ERR_NONE, 1'b0)),
      typed_row(CH_LF, 1'b0, 0, make_res(KIND_BYTE, 8'h00, ERR_NONE, 1'b0)),
      typed_row("q", 1'b0, 1, make_res(KIND_BYTE, "q", ERR_NONE, 1'b1)),
      // Illegal escape.
      typed_row(CH_BACKSLASH, 1'b0, 0, make_res(KIND_BYTE, 8'h00, ERR_NONE, 1'b0)),
      typed_row("q", 1'b0, 1, make_res(KIND_ERROR, 8'h00, ERR_ILLEGAL, 1'b1)),
      // Octal run with an underscore, ended by a decimal 9: two results.
      free_row(CH_BACKSLASH, 1'b0),
      free_row("3", 1'b0),
      free_row(CH_UNDERSCORE, 1'b0),
      free_row(CH_7, 1'b0),
      free_row("9", 1'b0),
      // End of source inside an octal run: the value, then the end error.
      free_row(CH_BACKSLASH, 1'b0),
      free_row("1", 1'b0),
      free_row(8'hA5, 1'b1),
      // Newline in text with closing required.
      typed_row(CH_LF, 1'b0, 1, make_res(KIND_ERROR, 8'h00, ERR_NEWLINE, 1'b1)),
      // End of source right after a backslash.
      typed_row(CH_BACKSLASH, 1'b0, 0, make_res(KIND_BYTE, 8'h00, ERR_NONE, 1'b0)),
      typed_row(8'h00, 1'b1, 1, make_res(KIND_ERROR, 8'h00, ERR_END, 1'b1)),
      // End of source in text with closing required.
      typed_row(8'hFF, 1'b1, 1, make_res(KIND_ERROR, 8'h00, ERR_END, 1'b1)),
      // Closing quote, then an escaped quote that must not close.
      typed_row(CH_DQUOTE, 1'b0, 1, make_res(KIND_CLOSE, 8'h00, ERR_NONE, 1'b1)),
      typed_row(CH_BACKSLASH, 1'b0, 0, make_res(KIND_BYTE, 8'h00, ERR_NONE, 1'b0)),
      typed_row(CH_DQUOTE, 1'b0, 1, make_res(KIND_BYTE, CH_DQUOTE, ERR_NONE, 1'b1))
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i]);

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      set_config(phase_quote[p], phase_close[p]);
      if (p == N_PHASES - 1) calm = 1'b1;
      phase_end = bytes_sent + RAND_ITEMS / N_PHASES;
      while (bytes_sent < phase_end) send_random_string();
    end
    drain_results();

    $display("Sent %0d source bytes: the directed table, then %0d random phases with",
             bytes_sent, N_PHASES);
    $display("their own register settings; checked %0d results (%0d bytes, %0d closes,",
             results_seen, kind_seen[0], kind_seen[1]);
    $display("%0d unclosed ends, %0d errors).", kind_seen[2], kind_seen[3]);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
